// ----- design/awe_pkg.sv -----
`timescale 1ns / 1ps
package awe_pkg;
  localparam int SampleBits  = 16;
  localparam int MaxChannels = 8;
  localparam logic [15:0] DefaultBinFrames = 16'd256;

  localparam logic [0:0] RegSamplesPerBin = 1'b0;
  localparam logic [0:0] RegChannelCount  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FOLD,
    ST_MEAN,
    ST_ROOT,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // accept sample into frame sum
    logic div_start;   // begin mono division
    logic fold;        // fold mono value into bin
    logic mean_start;  // begin mean divide
    logic root_start;  // begin square root
    logic emit;        // capture result into output register
    logic clear_bin;
    logic clear_all;
  } awe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_full;   // channel position reached count after load
    logic bin_full;     // bin reached frame count after fold
    logic partial;      // channel position nonzero
    logic emitted;      // a bin was emitted since buffer start
    logic unit_done;    // iterative unit finished
  } awe_sts_t;
endpackage

// ----- design/awe_datapath.sv -----
`timescale 1ns / 1ps
module awe_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  awe_pkg::awe_cmd_t      cmd,
  output awe_pkg::awe_sts_t      sts,
  input  logic [15:0]            sample,
  input  logic [15:0]            samples_per_bin,
  input  logic [3:0]             channel_count,
  output logic [15:0]            bin_min,
  output logic [14:0]            bin_max,
  output logic [15:0]            bin_peak,
  output logic [15:0]            bin_rms
);
  import awe_pkg::*;

  // a frame whose channel count shrank mid-frame can hold up to eight samples,
  // so the mono value and the bin statistics carry the full 19-bit magnitude
  logic signed [18:0] frame_sum;
  logic [3:0]  channel_position;
  logic [15:0] frames_in_bin;
  logic signed [19:0] running_min;
  logic [18:0] running_max;
  logic [18:0] running_peak;
  logic [52:0] square_sum;
  logic        emitted;

  logic [3:0]  eff_ch;
  logic [16:0] eff_bin;
  logic [18:0] mag;
  logic [5:0]  cnt;
  logic        root_mode;
  // shared shift-subtract divider
  logic [15:0] div_by;
  logic [52:0] quo;
  logic [15:0] rem;
  logic [16:0] rem_sh;
  // root
  logic [52:0] rval;
  logic [52:0] rroot;
  logic [52:0] rbit;
  logic [53:0] trial;
  logic [18:0] q;
  logic        neg;
  logic signed [19:0] mono;
  logic [37:0] qsq;

  always_comb begin
    eff_ch = channel_count;
    if (channel_count == 4'd0) eff_ch = 4'd1;
    if (channel_count > 4'(MaxChannels)) eff_ch = 4'(MaxChannels);
    eff_bin = (samples_per_bin == 16'd0) ? {1'b0, DefaultBinFrames} : {1'b0, samples_per_bin};
    mag = frame_sum[18] ? 19'(-frame_sum) : 19'(frame_sum);
    q = quo[18:0];
    mono = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    qsq = 38'(q) * 38'(q);
    rem_sh = {rem, quo[52]};
    trial = {1'b0, rroot} + {1'b0, rbit};
  end

  assign sts.frame_full = (channel_position >= eff_ch);
  assign sts.bin_full   = ({1'b0, frames_in_bin} >= eff_bin);
  assign sts.partial    = (channel_position != 4'd0);
  assign sts.emitted    = emitted;
  assign sts.unit_done  = (cnt == 6'd0);

  // frame accumulation
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      frame_sum <= '0;
      channel_position <= '0;
    end else if (cmd.load) begin
      frame_sum <= frame_sum + 19'(signed'(sample));
      channel_position <= channel_position + 4'd1;
    end else if (cmd.fold) begin
      frame_sum <= '0;
      channel_position <= '0;
    end
  end

  // note that a bin went out since the buffer began
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      emitted <= 1'b0;
    end else if (cmd.emit) begin
      emitted <= 1'b1;
    end
  end

  // fold the mono value into the bin
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_bin || cmd.clear_all) begin
      frames_in_bin <= '0;
      running_min <= '0;
      running_max <= '0;
      running_peak <= '0;
      square_sum <= '0;
    end else if (cmd.fold) begin
      if (mono < running_min) running_min <= mono;
      if (!neg && (q > running_max)) running_max <= q;
      if (q > running_peak) running_peak <= q;
      square_sum <= square_sum + 53'(qsq);
      frames_in_bin <= frames_in_bin + 16'd1;
    end
  end

  // iterative divider, then restoring square root, one bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      root_mode <= 1'b0;
    end else if (cmd.div_start) begin
      neg <= frame_sum[18];
      quo <= {mag, 34'd0};
      rem <= '0;
      div_by <= {12'd0, eff_ch};
      root_mode <= 1'b0;
      cnt <= 6'd19;
    end else if (cmd.mean_start) begin
      quo <= square_sum;
      rem <= '0;
      div_by <= frames_in_bin;
      root_mode <= 1'b0;
      cnt <= 6'd53;
    end else if (cmd.root_start) begin
      rval <= quo;
      rroot <= '0;
      rbit <= 53'(1) << 52;
      root_mode <= 1'b1;
      cnt <= 6'd27;
    end else if (cnt != 6'd0) begin
      cnt <= cnt - 6'd1;
      if (root_mode) begin
        if ({1'b0, rval} >= trial) begin
          rval <= 53'({1'b0, rval} - trial);
          rroot <= (rroot >> 1) + rbit;
        end else begin
          rroot <= rroot >> 1;
        end
        rbit <= rbit >> 2;
      end else begin
        if (rem_sh >= {1'b0, div_by}) begin
          rem <= 16'(rem_sh - {1'b0, div_by});
          quo <= {quo[51:0], 1'b1};
        end else begin
          rem <= rem_sh[15:0];
          quo <= {quo[51:0], 1'b0};
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      bin_min  <= running_min[15:0];
      bin_max  <= running_max[14:0];
      bin_peak <= running_peak[15:0];
      bin_rms  <= (frames_in_bin == 16'd0) ? 16'd0 : rroot[15:0];
    end
  end
endmodule

// ----- design/awe_ctrl.sv -----
`timescale 1ns / 1ps
module awe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_ready,
  input  awe_pkg::awe_sts_t sts,
  output awe_pkg::awe_cmd_t cmd
);
  import awe_pkg::*;

  state_t state, state_next;
  logic last_r, last_r_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      last_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      last_r <= last_r_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    last_r_next = last_r;
    out_valid_next = out_valid && !out_ready;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          last_r_next = last;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        // decide whether this sample closes a frame, or whether last flushes the bin
        if (sts.frame_full || (last_r && !sts.emitted && sts.partial)) begin
          cmd.div_start = 1'b1;
          state_next = ST_FOLD;
        end else if (last_r && !sts.emitted) begin
          cmd.mean_start = 1'b1;
          state_next = ST_MEAN;
        end else begin
          cmd.clear_all = last_r;
          state_next = ST_IDLE;
        end
      end
      ST_FOLD: begin
        if (sts.unit_done) begin
          cmd.fold = 1'b1;
          state_next = ST_MEAN;
        end
      end
      ST_MEAN: begin
        // after fold: bin full, or flush on last
        if (sts.bin_full || (last_r && !sts.emitted)) begin
          cmd.mean_start = 1'b1;
          state_next = ST_ROOT;
        end else begin
          cmd.clear_all = last_r;
          state_next = ST_IDLE;
        end
      end
      ST_ROOT: begin
        if (sts.unit_done) begin
          cmd.root_start = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until root done and output register free
        if (sts.unit_done && (!out_valid || out_ready)) begin
          cmd.emit = 1'b1;
          cmd.clear_bin = 1'b1;
          cmd.clear_all = last_r;
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ----- design/audio_waveform_envelope_binner_unit.sv -----
`timescale 1ns / 1ps
// Min/max/peak/RMS envelope binner for interleaved Q1.15 audio. One sample
// is taken per transfer, and the next only once the previous is through. A
// sample that closes a frame also runs the mono divide on a shared
// shift-subtract unit; one that closes a bin also runs the mean divide and
// the square root on the same unit, and may wait for the result register
// to be taken. The result register lets the next sample enter while a bin
// waits to be taken. Write the registers only while idle.
module audio_waveform_envelope_binner_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] sample,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] bin_min,
  output logic [14:0] bin_max,
  output logic [15:0] bin_peak,
  output logic [15:0] bin_rms,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import awe_pkg::*;

  logic [15:0] samples_per_bin;
  logic [3:0]  channel_count;
  awe_cmd_t cmd;
  awe_sts_t sts;

  assign pready = 1'b1;
  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_bin <= DefaultBinFrames;
      channel_count <= 4'd2;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegSamplesPerBin) samples_per_bin <= pwdata[15:0];
      else channel_count <= pwdata[3:0];
    end
  end
  assign prdata = (paddr[2] == RegChannelCount) ? {28'd0, channel_count}
                                                : {16'd0, samples_per_bin};

  awe_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .last, .out_valid, .out_ready, .sts, .cmd
  );
  awe_datapath u_dp (
    .clk, .rst, .cmd, .sts, .sample, .samples_per_bin, .channel_count,
    .bin_min, .bin_max, .bin_peak, .bin_rms
  );
endmodule

// ----- design/awe_checker.sv -----
`timescale 1ns / 1ps
module awe_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] bin_min,
  input logic [14:0] bin_max,
  input logic [15:0] bin_peak
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bin_peak)) else $error("out dropped");
  a_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bin_min[15] || bin_min == 16'd0) else $error("min positive");
  a_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bin_peak >= {1'b0, bin_max}) else $error("peak below max");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
endmodule

bind audio_waveform_envelope_binner_unit awe_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .bin_min, .bin_max, .bin_peak
);
